@@ hw/rtl/sfd_pkg.sv @@
// Shared types, constants and arithmetic helpers for the stereo feedback delay.
package sfd_pkg;

   localparam int SAMPLE_W    = 24;
   localparam int GAIN_W      = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int PROD_W      = SAMPLE_W + GAIN_W + 1;
   localparam int ROUND_W     = PROD_W - 15;
   localparam int SUM_W       = ROUND_W + 1;

   localparam logic [GAIN_W-1:0] WET_GAIN   = 16'd22938;
   localparam logic [GAIN_W-1:0] GAIN_MAX   = 16'd36045;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

   localparam logic signed [SUM_W-1:0]  SUM_MAX   = 27'sd8388607;
   localparam logic signed [SUM_W-1:0]  SUM_MIN   = -27'sd8388608;
   localparam logic signed [PROD_W-1:0] ROUND_BIAS = 41'sd16384;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [GAIN_W-1:0]          gain_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DELAY_SAMPLES = 2'd0,
      CSR_FEEDBACK_GAIN = 2'd1
   } csr_index_type;

   // Per-stage load strobes and read qualifiers sent from the control to each lane.
   typedef struct packed {
      logic ld1;
      logic ld2;
      logic ld3;
      logic ld4;
      logic wr_en;
      logic rd_live;
      logic zero_delay;
   } lane_ctrl_type;

   // Q1.15 product rounded to nearest, ties toward plus infinity.
   function automatic logic signed [ROUND_W-1:0] round_q15(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] biased;
      biased = p + ROUND_BIAS;
      return biased[PROD_W-1:15];
   endfunction

   // Clamp a wide sum into the signed 24-bit sample range.
   function automatic sample_type sat_sample(input logic signed [SUM_W-1:0] v);
      sample_type r;
      if (v > SUM_MAX) begin
         r = SUM_MAX[SAMPLE_W-1:0];
      end else if (v < SUM_MIN) begin
         r = SUM_MIN[SAMPLE_W-1:0];
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/sfd_lane.sv @@
// One channel lane: delay memory plus the four-stage echo arithmetic.
module sfd_lane #(
   parameter int  DEPTH = 65536,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  sfd_pkg::lane_ctrl_type ctrl,
   input  sfd_pkg::sample_type   x_in,
   input  logic [AW-1:0]         rd_addr,
   input  logic [AW-1:0]         wr_addr,
   input  sfd_pkg::gain_type     gain,
   output sfd_pkg::sample_type   y_out
);

   sfd_pkg::sample_type mem [DEPTH];

   sfd_pkg::sample_type x1_ff, rdata_ff;
   logic                live1_ff, zero1_ff;
   sfd_pkg::sample_type x2_ff, w2_ff, m2_ff;
   logic                zero2_ff;
   sfd_pkg::sample_type y3_ff, w3_ff;
   sfd_pkg::sample_type y4_ff, w4_ff;
   logic signed [sfd_pkg::PROD_W-1:0] p4_ff;

   logic signed [sfd_pkg::PROD_W-1:0] wet_prod;
   logic signed [sfd_pkg::GAIN_W:0]   wet_gain_s;
   logic signed [sfd_pkg::GAIN_W:0]   fb_gain_s;
   sfd_pkg::sample_type               w2_in, m2_in, y3_in, fb_in, tap;
   logic signed [sfd_pkg::PROD_W-1:0] p4_in;

   assign wet_gain_s = {1'b0, sfd_pkg::WET_GAIN};
   assign fb_gain_s  = {1'b0, gain};

   // Stage 1: dry sample scaled by 0.7 becomes the value first written at the pointer.
   assign wet_prod = x1_ff * wet_gain_s;
   assign w2_in    = sfd_pkg::sat_sample(sfd_pkg::SUM_W'(sfd_pkg::round_q15(wet_prod)));
   assign m2_in    = live1_ff ? rdata_ff : '0;

   // Stage 2: with zero delay the tap is the entry just written.
   assign tap   = zero2_ff ? w2_ff : m2_ff;
   assign y3_in = sfd_pkg::sat_sample(sfd_pkg::SUM_W'(x2_ff) + sfd_pkg::SUM_W'(tap));

   // Stage 3: feedback product.
   assign p4_in = y3_ff * fb_gain_s;

   // Stage 4: final entry value.
   assign fb_in = sfd_pkg::sat_sample(sfd_pkg::SUM_W'(w4_ff) +
                                      sfd_pkg::SUM_W'(sfd_pkg::round_q15(p4_ff)));

   always_ff @(posedge clock) begin
      if (ctrl.ld1) begin
         rdata_ff <= mem[rd_addr];
      end
      if (ctrl.wr_en) begin
         mem[wr_addr] <= fb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld1) begin
         x1_ff    <= x_in;
         live1_ff <= ctrl.rd_live;
         zero1_ff <= ctrl.zero_delay;
      end
      if (ctrl.ld2) begin
         x2_ff    <= x1_ff;
         w2_ff    <= w2_in;
         m2_ff    <= m2_in;
         zero2_ff <= zero1_ff;
      end
      if (ctrl.ld3) begin
         y3_ff <= y3_in;
         w3_ff <= w2_ff;
      end
      if (ctrl.ld4) begin
         p4_ff <= p4_in;
         w4_ff <= w3_ff;
         y4_ff <= y3_ff;
      end
   end

   assign y_out = y4_ff;

endmodule

@@ hw/rtl/stereo_feedback_delay.sv @@
// Top level of the stereo feedback delay: control, two channel lanes and the output stage.
// Each accepted frame moves through the lane stages and then into the output register;
// its memory write lands as it leaves the last lane stage.
// Throughput: one frame per clock when the delay is zero or at least five samples and the
// receiver does not stall; for delays of one to four the next frame waits until the
// memory write it depends on lands. Reset clears the pointer, the fill flag and the
// pipeline valids, and returns the registers to no delay and half gain; the delay memories
// read as zero until written, so no clearing pass is needed.
module stereo_feedback_delay #(
   parameter int DEPTH = 65536
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  sfd_pkg::sample_type               req_left_in,
   input  sfd_pkg::sample_type               req_right_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output sfd_pkg::sample_type               rsp_left_out,
   output sfd_pkg::sample_type               rsp_right_out,
   input  logic                              csr_write,
   input  logic [sfd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sfd_pkg::GAIN_W-1:0]        csr_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = (AW > sfd_pkg::GAIN_W) ? AW : sfd_pkg::GAIN_W;
   localparam logic [CW-1:0] DELAY_MAX = CW'(DEPTH - 1);
   localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] PTR_LAST  = AW'(DEPTH - 1);

   // Configuration registers hold values already clamped to their legal range.
   logic [AW-1:0]     delay_ff, delay_in;
   sfd_pkg::gain_type gain_ff, gain_in;

   // Shared write pointer and a flag that is set once the pointer has wrapped past the last entry.
   logic [AW-1:0] wp_ff, wp_in;
   logic          wrapped_ff, wrapped_in;

   // Pipeline occupancy and the pointer each in-flight transaction will write.
   logic          v1_ff, v2_ff, v3_ff, v4_ff, vo_ff;
   logic [AW-1:0] wp1_ff, wp2_ff, wp3_ff, wp4_ff;

   sfd_pkg::sample_type rsp_left_ff, rsp_right_ff;
   sfd_pkg::sample_type left_y, right_y;

   logic          ready_o, ready4, ready3, ready2, ready1;
   logic          mv1, mv2, mv3, mv4, accept;
   logic [AW:0]   rd_diff, rd_wrap;
   logic [AW-1:0] rd_addr;
   logic          zero_delay, rd_live, rd_hit, hazard;
   logic [CW-1:0] csr_delay_ext;
   sfd_pkg::lane_ctrl_type lane_ctrl;

   // Configuration decode; writes to unknown indexes are dropped.
   assign csr_delay_ext = CW'(csr_data);

   always_comb begin
      delay_in = delay_ff;
      gain_in  = gain_ff;
      if (csr_write) begin
         unique case (csr_index)
            sfd_pkg::CSR_DELAY_SAMPLES: begin
               delay_in = (csr_delay_ext > DELAY_MAX) ? AW'(DELAY_MAX) : AW'(csr_delay_ext);
            end
            sfd_pkg::CSR_FEEDBACK_GAIN: begin
               gain_in = (csr_data > sfd_pkg::GAIN_MAX) ? sfd_pkg::GAIN_MAX : csr_data;
            end
            default: begin
               delay_in = delay_ff;
            end
         endcase
      end
   end

   // Read address is delay entries behind the pointer, modulo the depth.
   assign rd_diff    = {1'b0, wp_ff} - {1'b0, delay_ff};
   assign rd_wrap    = rd_diff + DEPTH_EXT;
   assign rd_addr    = rd_diff[AW] ? rd_wrap[AW-1:0] : rd_diff[AW-1:0];
   assign zero_delay = (delay_ff == '0);

   // Before the first wrap only entries below the pointer hold written data.
   assign rd_live = wrapped_ff || (rd_addr < wp_ff);

   // A transaction still in the pipeline that will write the entry we want to read
   // blocks acceptance until its write has landed in memory.
   assign rd_hit = (v1_ff && (wp1_ff == rd_addr)) || (v2_ff && (wp2_ff == rd_addr)) ||
                   (v3_ff && (wp3_ff == rd_addr)) || (v4_ff && (wp4_ff == rd_addr));
   assign hazard = !zero_delay && rd_hit;

   // Backpressure chain: each stage moves when the one after it has room.
   assign ready_o = !vo_ff || !rsp_stall;
   assign mv4     = v4_ff && ready_o;
   assign ready4  = !v4_ff || ready_o;
   assign mv3     = v3_ff && ready4;
   assign ready3  = !v3_ff || ready4;
   assign mv2     = v2_ff && ready3;
   assign ready2  = !v2_ff || ready3;
   assign mv1     = v1_ff && ready2;
   assign ready1  = !v1_ff || ready2;

   assign req_stall = !ready1 || hazard;
   assign accept    = req_valid && !req_stall;

   assign wp_in      = accept ? ((wp_ff == PTR_LAST) ? '0 : wp_ff + 1'b1) : wp_ff;
   assign wrapped_in = wrapped_ff || (accept && (wp_ff == PTR_LAST));

   always_comb begin
      lane_ctrl.ld1        = accept;
      lane_ctrl.ld2        = mv1;
      lane_ctrl.ld3        = mv2;
      lane_ctrl.ld4        = mv3;
      lane_ctrl.wr_en      = mv4;
      lane_ctrl.rd_live    = rd_live;
      lane_ctrl.zero_delay = zero_delay;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff   <= '0;
         gain_ff    <= sfd_pkg::GAIN_RESET;
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         vo_ff      <= 1'b0;
      end else begin
         delay_ff   <= delay_in;
         gain_ff    <= gain_in;
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
         v1_ff      <= accept | (v1_ff & !mv1);
         v2_ff      <= mv1 | (v2_ff & !mv2);
         v3_ff      <= mv2 | (v3_ff & !mv3);
         v4_ff      <= mv3 | (v4_ff & !mv4);
         vo_ff      <= mv4 | (vo_ff & rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         wp1_ff <= wp_ff;
      end
      if (mv1) begin
         wp2_ff <= wp1_ff;
      end
      if (mv2) begin
         wp3_ff <= wp2_ff;
      end
      if (mv3) begin
         wp4_ff <= wp3_ff;
      end
      // The output stage merges both lanes into one result transaction.
      if (mv4) begin
         rsp_left_ff  <= left_y;
         rsp_right_ff <= right_y;
      end
   end

   sfd_lane #(.DEPTH(DEPTH)) u_left (
      .clock   (clock),
      .ctrl    (lane_ctrl),
      .x_in    (req_left_in),
      .rd_addr (rd_addr),
      .wr_addr (wp4_ff),
      .gain    (gain_ff),
      .y_out   (left_y)
   );

   sfd_lane #(.DEPTH(DEPTH)) u_right (
      .clock   (clock),
      .ctrl    (lane_ctrl),
      .x_in    (req_right_in),
      .rd_addr (rd_addr),
      .wr_addr (wp4_ff),
      .gain    (gain_ff),
      .y_out   (right_y)
   );

   assign rsp_valid     = vo_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

   // The pointer never leaves the memory.
   a_wp_range: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= PTR_LAST)
      else $error("write pointer beyond depth");

   // The fill flag rises only when the pointer wraps from the last entry to zero.
   a_wrap: assert property (@(posedge clock) disable iff (reset)
      $rose(wrapped_ff) |-> (wp_ff == '0) && ($past(wp_ff) == PTR_LAST))
      else $error("fill flag set without pointer wrap");

   // An accepted transaction occupies the first stage on the next cycle.
   a_accept_fill: assert property (@(posedge clock) disable iff (reset)
      accept |=> v1_ff && (wp1_ff == $past(wp_ff)))
      else $error("accepted transaction lost from first stage");

   // A transaction is never accepted while the one in the last stage still owes the entry it reads.
   a_no_stale_read: assert property (@(posedge clock) disable iff (reset)
      accept && !zero_delay |-> !(v4_ff && (wp4_ff == rd_addr)))
      else $error("read issued ahead of pending write");

   // Reset clears the output valid and the first and last stage valids.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !v1_ff && !v4_ff)
      else $error("pipeline not empty after reset");

endmodule

@@ test/tb_stereo_feedback_delay.sv @@
// Self-checking testbench for the stereo feedback delay: stimulus, echo predictor and checks.
`timescale 1ns / 100ps

module tb_stereo_feedback_delay;

   // The delay memory depth used both for the block and for the predictor's own copy.
   localparam int unsigned DEPTH_TB = 65536;

   // Cycles without any transaction, register write or result before the run is abandoned.
   localparam int unsigned STUCK_LIMIT = 5000;

   // Cycles to keep watching the result side once nothing is expected any more.
   localparam int unsigned DRAIN_CYCLES = 20;

   // Percentage of cycles in which either side idles or stalls outside the calm stretch.
   localparam int unsigned IDLE_PERCENT = 26;

   // The register index field has room for two indexes that map to nothing.
   localparam logic [sfd_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [sfd_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;

   localparam sfd_pkg::sample_type PEAK_HI = 24'sh7FFFFF;
   localparam sfd_pkg::sample_type PEAK_LO = 24'sh800000;

   localparam longint ROUND_HALF = 64'sd16384;
   localparam int Q15_SHIFT = 15;

   // One stereo result frame as the block should deliver it.
   typedef struct {
      sfd_pkg::sample_type left;
      sfd_pkg::sample_type right;
   } echo_frame_type;

   // The scoreboard holds its own copy of both delay memories, the shared write
   // pointer and the two registers. Every accepted input transaction is run
   // through that copy at once and the expected frame is queued; every accepted
   // result transaction is compared against the oldest queued frame.
   class echo_scoreboard;
      bit signed [sfd_pkg::SAMPLE_W-1:0] echo_store [2][DEPTH_TB];
      int unsigned head;
      int unsigned delay_reg;
      int unsigned gain_reg;
      echo_frame_type frames_due[$];
      int unsigned failures;

      function new();
         head = 0;
         delay_reg = 0;
         gain_reg = sfd_pkg::GAIN_RESET;
         failures = 0;
      endfunction

      task report_mismatch(string msg);
         failures++;
         $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      function void set_register(logic [sfd_pkg::CSR_INDEX_W-1:0] idx,
                                 logic [sfd_pkg::GAIN_W-1:0] data);
         case (idx)
            sfd_pkg::CSR_DELAY_SAMPLES: begin
               delay_reg = data;
            end
            sfd_pkg::CSR_FEEDBACK_GAIN: begin
               gain_reg = data;
            end
            default: begin
               // Writes to unused indexes leave both registers alone.
            end
         endcase
      endfunction

      // Clamp to the signed 24-bit sample range.
      function sfd_pkg::sample_type clip(longint v);
         if (v > longint'(PEAK_HI)) begin
            return PEAK_HI;
         end else if (v < longint'(PEAK_LO)) begin
            return PEAK_LO;
         end
         return sfd_pkg::sample_type'(v);
      endfunction

      // Sample times an unsigned Q1.15 gain, rounded half up (floor of p + half).
      function longint scale(longint x, int unsigned g);
         return (x * longint'(g) + ROUND_HALF) >>> Q15_SHIFT;
      endfunction

      // One channel's read-modify-write. When the tap equals the head (zero
      // delay) the read sees the wet sample written just before it.
      function sfd_pkg::sample_type echo_channel(int ch, sfd_pkg::sample_type x,
                                                 int unsigned tap, int unsigned g);
         sfd_pkg::sample_type y;
         echo_store[ch][head] = clip(scale(x, sfd_pkg::WET_GAIN));
         y = clip(longint'(x) + longint'(echo_store[ch][tap]));
         echo_store[ch][head] = clip(longint'(echo_store[ch][head]) + scale(y, g));
         return y;
      endfunction

      function void note_frame(sfd_pkg::sample_type l, sfd_pkg::sample_type r);
         int unsigned d;
         int unsigned g;
         int unsigned tap;
         echo_frame_type f;
         d = (delay_reg > DEPTH_TB - 1) ? DEPTH_TB - 1 : delay_reg;
         g = (gain_reg > sfd_pkg::GAIN_MAX) ? sfd_pkg::GAIN_MAX : gain_reg;
         tap = (head + DEPTH_TB - d) % DEPTH_TB;
         f.left = echo_channel(0, l, tap, g);
         f.right = echo_channel(1, r, tap, g);
         head = (head + 1) % DEPTH_TB;
         frames_due.insert(frames_due.size(), f);
      endfunction

      task check_frame(sfd_pkg::sample_type l, sfd_pkg::sample_type r);
         echo_frame_type f;
         if (frames_due.size() == 0) begin
            report_mismatch($sformatf("result %0d/%0d arrived with nothing expected", l, r));
            return;
         end
         f = frames_due.pop_front();
         if (l !== f.left) begin
            report_mismatch($sformatf("left_out %0d, expected %0d", l, f.left));
         end
         if (r !== f.right) begin
            report_mismatch($sformatf("right_out %0d, expected %0d", r, f.right));
         end
      endtask

      function int unsigned pending();
         return frames_due.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   sfd_pkg::sample_type req_left_in;
   sfd_pkg::sample_type req_right_in;
   logic rsp_valid;
   logic rsp_stall;
   sfd_pkg::sample_type rsp_left_out;
   sfd_pkg::sample_type rsp_right_out;
   logic csr_write;
   logic [sfd_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [sfd_pkg::GAIN_W-1:0] csr_data;

   echo_scoreboard sb;

   // While set, neither the sender idles nor the receiver stalls.
   bit calm_stretch;

   int unsigned quiet_cycles = 0;

   stereo_feedback_delay #(
      .DEPTH(DEPTH_TB)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_left_in(req_left_in),
      .req_right_in(req_right_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_left_out(rsp_left_out),
      .rsp_right_out(rsp_right_out),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // The receiver stalls at random, except during the calm stretch.
   always @(posedge clock) begin
      rsp_stall <= !calm_stretch && ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   // Both channels are sampled at the clock edge, before the block's own
   // updates of that edge land, so the values seen are the ones the block saw.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_frame(rsp_left_out, rsp_right_out);
         end
         if (req_valid && !req_stall) begin
            sb.note_frame(req_left_in, req_right_in);
         end
      end
   end

   // The watchdog restarts its count on every transaction or register write.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STUCK_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Half of the samples full-range, the rest rails, zero, minus one and
   // quiet material so that both saturation and long echo tails show up.
   function automatic sfd_pkg::sample_type pick_sample();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         return PEAK_HI;
      end else if (roll < 20) begin
         return PEAK_LO;
      end else if (roll < 25) begin
         return '0;
      end else if (roll < 30) begin
         return '1;
      end else if (roll < 50) begin
         return sfd_pkg::sample_type'(int'($urandom_range(0, 4095)) - 2048);
      end
      return sfd_pkg::sample_type'($urandom);
   endfunction

   // Presents one input transaction and returns at the edge that accepts it.
   // The valid stays high between back-to-back transactions.
   task automatic send_frame(input sfd_pkg::sample_type l, input sfd_pkg::sample_type r);
      while (!calm_stretch && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_left_in <= l;
      req_right_in <= r;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   // Drops the valid and holds off until every expected frame has come back,
   // which leaves the block idle for register writes. The first wait makes
   // sure the transaction accepted at the previous edge has been noted.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_register(input logic [sfd_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [sfd_pkg::GAIN_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      sb.set_register(idx, data);
      @(posedge clock);
   endtask

   // Writes both registers back to back, then pokes the two unused indexes
   // with junk that must not disturb either register.
   task automatic configure(input int unsigned delay_val, input int unsigned gain_val);
      int unsigned junk;
      write_register(sfd_pkg::CSR_DELAY_SAMPLES, delay_val[sfd_pkg::GAIN_W-1:0]);
      write_register(sfd_pkg::CSR_FEEDBACK_GAIN, gain_val[sfd_pkg::GAIN_W-1:0]);
      junk = $urandom;
      write_register(CSR_SPARE_LO, junk[sfd_pkg::GAIN_W-1:0]);
      junk = $urandom;
      write_register(CSR_SPARE_HI, junk[sfd_pkg::GAIN_W-1:0]);
      csr_write <= 1'b0;
   endtask

   task automatic run_phase(input int unsigned delay_val, input int unsigned gain_val,
                            input int unsigned count);
      configure(delay_val, gain_val);
      repeat (count) begin
         send_frame(pick_sample(), pick_sample());
      end
      drain();
   endtask

   initial begin
      sb = new();
      calm_stretch = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_left_in <= '0;
      req_right_in <= '0;
      csr_write <= 1'b0;
      csr_index <= sfd_pkg::CSR_DELAY_SAMPLES;
      csr_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed frames at the reset settings: zero delay and half gain, so
      // every output is the input plus its own wet copy, saturated.
      send_frame(PEAK_HI, PEAK_HI);
      send_frame(PEAK_LO, PEAK_LO);
      send_frame('0, '0);
      send_frame('1, 24'sd1);
      send_frame(PEAK_HI, PEAK_LO);
      send_frame(PEAK_LO, PEAK_HI);
      send_frame(24'sd1, '1);
      send_frame(24'sh400000, 24'shC00000);
      send_frame(24'sh4B4B4B, 24'shB4B4B5);
      send_frame(24'sd3, -24'sd3);
      send_frame(24'sh555555, 24'shAAAAAA);
      send_frame(24'sd1, 24'sd2);
      drain();

      // Short delays make the block hold off on the memory hazard; the gains
      // cover zero, the top of the range and values beyond it that clamp.
      run_phase(1, sfd_pkg::GAIN_RESET, 40);
      run_phase(2, sfd_pkg::GAIN_MAX, 30);
      run_phase(3, 16'hFFFF, 30);
      run_phase(4, 0, 30);
      run_phase(5, 30000, 40);
      run_phase(0, sfd_pkg::GAIN_MAX + 1, 30);

      // The longest delay reads the entry just ahead of the pointer.
      run_phase(DEPTH_TB - 1, 20000, 30);

      // A long stretch with neither side idling, and the largest feedback gain so
      // the echoes pile up into saturation.
      calm_stretch = 1'b1;
      run_phase(7, sfd_pkg::GAIN_MAX, 100);
      calm_stretch = 1'b0;

      // Random settings: mostly short delays so echoes come back inside the
      // phase, now and then any delay and any gain code.
      repeat (4) begin
         run_phase(($urandom_range(0, 3) == 0) ? $urandom_range(0, DEPTH_TB - 1)
                                               : $urandom_range(0, 24),
                   $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                        : $urandom_range(0, sfd_pkg::GAIN_MAX),
                   40);
      end

      // Keep watching for stray results for a while after the last one.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
